// ===== rtl/multichannel_byte_frame_router_defines.svh =====
`ifndef MULTICHANNEL_BYTE_FRAME_ROUTER_DEFINES_SVH
`define MULTICHANNEL_BYTE_FRAME_ROUTER_DEFINES_SVH

// Checked property, quiet while reset is asserted.
`define MBFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked property with no reset qualifier.
`define MBFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/mbfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbfr_pkg;

  localparam int unsigned NumChannelsDef = 5;
  localparam int unsigned MsgCapacityDef = 256;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned IdxOutW = 8;
  localparam int unsigned LenOutW = 9;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] StartBaseRst = 8'hD1;
  localparam logic [ByteW-1:0] EndCodeRst   = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartBase = 1'b0,
    CfgEndCode   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             is_start;
    logic             is_end;
    logic [ChanW-1:0] chan;
  } byte_class_t;

  typedef struct packed {
    logic               payload_valid;
    logic [ChanW-1:0]   payload_channel;
    logic [IdxOutW-1:0] payload_index;
    logic [ByteW-1:0]   payload_data;
    logic               overflow;
    logic               frame_done;
    logic [ChanW-1:0]   done_channel;
    logic [LenOutW-1:0] done_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/mbfr_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbfr_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mbfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mbfr_pkg::ByteW-1:0]   cfg_wdata_i,
  output logic [mbfr_pkg::ByteW-1:0]        start_base_o,
  output logic [mbfr_pkg::ByteW-1:0]        end_code_o
);

  logic [mbfr_pkg::ByteW-1:0] start_base_q, start_base_d;
  logic [mbfr_pkg::ByteW-1:0] end_code_q, end_code_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    start_base_d = start_base_q;
    end_code_d   = end_code_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (mbfr_pkg::cfg_reg_e'(cfg_index_i))
        mbfr_pkg::CfgStartBase: start_base_d = cfg_wdata_i;
        mbfr_pkg::CfgEndCode:   end_code_d   = cfg_wdata_i;
        default:                ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_base_q <= mbfr_pkg::StartBaseRst;
      end_code_q   <= mbfr_pkg::EndCodeRst;
    end else begin
      start_base_q <= start_base_d;
      end_code_q   <= end_code_d;
    end
  end

  assign start_base_o = start_base_q;
  assign end_code_o   = end_code_q;

endmodule

`default_nettype wire

// ===== rtl/mbfr_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbfr_classify #(
  parameter int unsigned NUM_CHANNELS = mbfr_pkg::NumChannelsDef
) (
  input  wire logic [mbfr_pkg::ByteW-1:0] rx_byte_i,
  input  wire logic [mbfr_pkg::ByteW-1:0] start_base_i,
  input  wire logic [mbfr_pkg::ByteW-1:0] end_code_i,
  output mbfr_pkg::byte_class_t           class_o
);

  logic [mbfr_pkg::ByteW:0] diff;
  logic                     start_hit;

  // borrow out of the subtract means the byte lies below start_base
  assign diff      = {1'b0, rx_byte_i} - {1'b0, start_base_i};
  assign start_hit = !diff[mbfr_pkg::ByteW] &&
                     (diff[mbfr_pkg::ByteW-1:0] < mbfr_pkg::ByteW'(NUM_CHANNELS));

  // start codes win over the end code when the two coincide
  assign class_o.is_start = start_hit;
  assign class_o.is_end   = !start_hit && (rx_byte_i == end_code_i);
  assign class_o.chan     = diff[mbfr_pkg::ChanW-1:0];

endmodule

`default_nettype wire

// ===== rtl/mbfr_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbfr_core #(
  parameter int unsigned NUM_CHANNELS = mbfr_pkg::NumChannelsDef,
  parameter int unsigned MSG_CAPACITY = mbfr_pkg::MsgCapacityDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic [mbfr_pkg::ByteW-1:0] rx_byte_i,
  input  wire mbfr_pkg::byte_class_t      class_i,
  output mbfr_pkg::result_t               result_o
);

  localparam int unsigned IdxW = $clog2(MSG_CAPACITY + 1);

  logic [NUM_CHANNELS-1:0]      toggle_q, toggle_d;
  logic [NUM_CHANNELS-1:0]      armed_q, armed_d;
  logic [IdxW-1:0]              widx_q, widx_d;
  logic [1:0]                   ecnt_q, ecnt_d;
  logic [IdxW-1:0]              llen_q, llen_d;
  logic [mbfr_pkg::ChanW-1:0]   dst;
  logic                         any_armed;
  mbfr_pkg::result_t            res;

  // lowest armed channel has priority
  always_comb begin
    dst = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (armed_q[i]) begin
        dst = mbfr_pkg::ChanW'(i);
      end
    end
  end

  assign any_armed = |armed_q;

  always_comb begin
    toggle_d = toggle_q;
    armed_d  = armed_q;
    widx_d   = widx_q;
    ecnt_d   = ecnt_q;
    llen_d   = llen_q;
    res      = '0;

    if (class_i.is_start) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (class_i.chan == mbfr_pkg::ChanW'(i)) begin
          // a start code mid-payload drops the channel and rewinds
          if (widx_q != '0) begin
            armed_d[i] = 1'b0;
            widx_d     = '0;
          end
          if (toggle_q[i]) begin
            toggle_d[i] = 1'b0;
            armed_d[i]  = 1'b1;
            ecnt_d      = '0;
            llen_d      = '0;
          end else begin
            toggle_d[i] = 1'b1;
          end
        end
      end
    end else begin
      if (class_i.is_end) begin
        toggle_d = '0;
        widx_d   = '0;
        if (ecnt_q != 2'd3) begin
          ecnt_d = ecnt_q + 2'd1;
        end
      end else if (any_armed) begin
        if (widx_q == IdxW'(MSG_CAPACITY)) begin
          res.overflow = 1'b1;
        end else begin
          res.payload_valid   = 1'b1;
          res.payload_channel = dst;
          res.payload_index   = mbfr_pkg::IdxOutW'(widx_q);
          res.payload_data    = rx_byte_i;
          widx_d              = widx_q + IdxW'(1);
          llen_d              = widx_q + IdxW'(1);
        end
      end

      // second end code hands over the message
      if (ecnt_d == 2'd2 && any_armed) begin
        res.frame_done   = 1'b1;
        res.done_channel = dst;
        res.done_length  = mbfr_pkg::LenOutW'(llen_d);
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (dst == mbfr_pkg::ChanW'(i)) begin
            armed_d[i] = 1'b0;
          end
        end
        ecnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      toggle_q <= '0;
      armed_q  <= '0;
      widx_q   <= '0;
      ecnt_q   <= '0;
      llen_q   <= '0;
    end else if (en_i) begin
      toggle_q <= toggle_d;
      armed_q  <= armed_d;
      widx_q   <= widx_d;
      ecnt_q   <= ecnt_d;
      llen_q   <= llen_d;
    end
  end

  assign result_o = res;

endmodule

`default_nettype wire

// ===== rtl/multichannel_byte_frame_router.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       sink       in_valid_i / in_stall_o   rx_byte_i
// out      source     out_valid_o / out_stall_i payload_*, overflow_o, frame_done_o, done_*
// cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_wdata_i
//
// One beat in, one beat out; a byte accepted into the input register passes through
// the decode/update step into the result register, from which it is taken on the output.
// Unstalled, the rate is one byte per cycle, set by the single decode/update step.
// Reset clears the channel state and both pipeline valids, and resets the configuration.
// A stall on the output holds the result register and backs up into the input
// register; the input is still taken while the input register is empty.

module multichannel_byte_frame_router #(
  parameter int unsigned NUM_CHANNELS = mbfr_pkg::NumChannelsDef,
  parameter int unsigned MSG_CAPACITY = mbfr_pkg::MsgCapacityDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [mbfr_pkg::ByteW-1:0]   rx_byte_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              payload_valid_o,
  output logic [mbfr_pkg::ChanW-1:0]        payload_channel_o,
  output logic [mbfr_pkg::IdxOutW-1:0]      payload_index_o,
  output logic [mbfr_pkg::ByteW-1:0]        payload_data_o,
  output logic                              overflow_o,
  output logic                              frame_done_o,
  output logic [mbfr_pkg::ChanW-1:0]        done_channel_o,
  output logic [mbfr_pkg::LenOutW-1:0]      done_length_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [mbfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [mbfr_pkg::ByteW-1:0]   cfg_wdata_i
);

  logic                       in_valid_q, in_valid_d;
  logic [mbfr_pkg::ByteW-1:0] in_byte_q;
  logic                       out_valid_q, out_valid_d;
  mbfr_pkg::result_t          result_q;
  mbfr_pkg::result_t          result;
  mbfr_pkg::byte_class_t      byte_class;
  logic [mbfr_pkg::ByteW-1:0] start_base;
  logic [mbfr_pkg::ByteW-1:0] end_code;
  logic                       adv;
  logic                       fire;
  logic                       in_take;

  mbfr_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_base_o (start_base),
    .end_code_o   (end_code)
  );

  mbfr_classify #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_classify (
    .rx_byte_i    (in_byte_q),
    .start_base_i (start_base),
    .end_code_i   (end_code),
    .class_o      (byte_class)
  );

  mbfr_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MSG_CAPACITY (MSG_CAPACITY)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (fire),
    .rx_byte_i (in_byte_q),
    .class_i   (byte_class),
    .result_o  (result)
  );

  // result register free, or emptied this cycle
  assign adv        = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = adv ? in_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_byte_i;
    end
    if (fire) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign payload_valid_o   = result_q.payload_valid;
  assign payload_channel_o = result_q.payload_channel;
  assign payload_index_o   = result_q.payload_index;
  assign payload_data_o    = result_q.payload_data;
  assign overflow_o        = result_q.overflow;
  assign frame_done_o      = result_q.frame_done;
  assign done_channel_o    = result_q.done_channel;
  assign done_length_o     = result_q.done_length;

endmodule

`default_nettype wire

// ===== rtl/mbfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_byte_frame_router_defines.svh"

module mbfr_checker #(
  parameter int unsigned NUM_CHANNELS = mbfr_pkg::NumChannelsDef
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic                         payload_valid_o,
  input wire logic [mbfr_pkg::ChanW-1:0]   payload_channel_o,
  input wire logic [mbfr_pkg::IdxOutW-1:0] payload_index_o,
  input wire logic [mbfr_pkg::ByteW-1:0]   payload_data_o,
  input wire logic                         overflow_o,
  input wire logic                         frame_done_o,
  input wire logic [mbfr_pkg::ChanW-1:0]   done_channel_o,
  input wire logic [mbfr_pkg::LenOutW-1:0] done_length_o
);

  // a byte is either stored or dropped, never both
  `MBFR_ASSERT(a_store_xor_drop, out_valid_o |-> !(payload_valid_o && overflow_o), "stored and dropped")

  `MBFR_ASSERT(a_payload_idle_zero, (out_valid_o && !payload_valid_o) |-> (payload_channel_o == '0 && payload_index_o == '0 && payload_data_o == '0), "payload fields not cleared")

  `MBFR_ASSERT(a_done_idle_zero, (out_valid_o && !frame_done_o) |-> (done_channel_o == '0 && done_length_o == '0), "done fields not cleared")

  `MBFR_ASSERT(a_channel_range, (out_valid_o && (payload_valid_o || frame_done_o)) |-> (payload_channel_o < mbfr_pkg::ChanW'(NUM_CHANNELS) && done_channel_o < mbfr_pkg::ChanW'(NUM_CHANNELS)), "channel out of range")

  `MBFR_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> out_valid_o, "stalled beat dropped")

endmodule

bind multichannel_byte_frame_router mbfr_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_mbfr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .payload_valid_o   (payload_valid_o),
  .payload_channel_o (payload_channel_o),
  .payload_index_o   (payload_index_o),
  .payload_data_o    (payload_data_o),
  .overflow_o        (overflow_o),
  .frame_done_o      (frame_done_o),
  .done_channel_o    (done_channel_o),
  .done_length_o     (done_length_o)
);

`default_nettype wire
